// ----- hw/rtl/mi3_pkg.sv -----
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned NumEl    = 9;

  typedef struct packed {
    logic signed [31:0] in_e0;
    logic signed [31:0] in_e1;
    logic signed [31:0] in_e2;
    logic signed [31:0] in_e3;
    logic signed [31:0] in_e4;
    logic signed [31:0] in_e5;
    logic signed [31:0] in_e6;
    logic signed [31:0] in_e7;
    logic signed [31:0] in_e8;
    logic               transpose_out;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_e0;
    logic signed [31:0] out_e1;
    logic signed [31:0] out_e2;
    logic signed [31:0] out_e3;
    logic signed [31:0] out_e4;
    logic signed [31:0] out_e5;
    logic signed [31:0] out_e6;
    logic signed [31:0] out_e7;
    logic signed [31:0] out_e8;
    logic signed [31:0] determinant;
    logic               singular;
  } out_beat_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh0_7FFF_FFFF;
    lo = -66'sh0_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ----- hw/rtl/mi3_if.sv -----
`timescale 1ns / 1ps
interface mi3_in_if;
  logic               valid;
  logic               ready;
  mi3_pkg::in_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mi3_out_if;
  logic               valid;
  logic               ready;
  mi3_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/matrix3x3_inverse_core.sv -----
`timescale 1ns / 1ps
// 3x3 inverse of a signed Q16.16 matrix by adjugate over determinant. One beat
// per cycle enters unless the output stalls. Stages: input register, minor
// products, minors, determinant products, determinant, divider setup, one
// quotient bit per stage over 32 restoring-divider stages, output register.
// The pipeline moves as one; it holds only when a finished beat waits at output.
module matrix3x3_inverse_core (
  input  logic clk_i,
  input  logic rst_ni,
  mi3_in_if.sink    in_i,
  mi3_out_if.source out_o
);

  localparam int unsigned NE = mi3_pkg::NumEl;
  localparam int unsigned NS = mi3_pkg::DivSteps;

  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // stage 1: input register
  logic               v1_q;
  logic signed [31:0] e1_q [NE];
  logic               tr1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q[0] <= in_i.data.in_e0;
      e1_q[1] <= in_i.data.in_e1;
      e1_q[2] <= in_i.data.in_e2;
      e1_q[3] <= in_i.data.in_e3;
      e1_q[4] <= in_i.data.in_e4;
      e1_q[5] <= in_i.data.in_e5;
      e1_q[6] <= in_i.data.in_e6;
      e1_q[7] <= in_i.data.in_e7;
      e1_q[8] <= in_i.data.in_e8;
      tr1_q   <= in_i.data.transpose_out;
    end
  end

  // stage 2: the 18 products of the minors
  logic               v2_q;
  logic signed [63:0] pa2_q [NE];
  logic signed [63:0] pb2_q [NE];
  logic signed [31:0] c2_q [3];
  logic               tr2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa2_q[0] <= e1_q[4] * e1_q[8];  pb2_q[0] <= e1_q[5] * e1_q[7];
      pa2_q[1] <= e1_q[7] * e1_q[2];  pb2_q[1] <= e1_q[1] * e1_q[8];
      pa2_q[2] <= e1_q[1] * e1_q[5];  pb2_q[2] <= e1_q[2] * e1_q[4];
      pa2_q[3] <= e1_q[6] * e1_q[5];  pb2_q[3] <= e1_q[3] * e1_q[8];
      pa2_q[4] <= e1_q[0] * e1_q[8];  pb2_q[4] <= e1_q[6] * e1_q[2];
      pa2_q[5] <= e1_q[2] * e1_q[3];  pb2_q[5] <= e1_q[0] * e1_q[5];
      pa2_q[6] <= e1_q[3] * e1_q[7];  pb2_q[6] <= e1_q[6] * e1_q[4];
      pa2_q[7] <= e1_q[1] * e1_q[6];  pb2_q[7] <= e1_q[0] * e1_q[7];
      pa2_q[8] <= e1_q[0] * e1_q[4];  pb2_q[8] <= e1_q[1] * e1_q[3];
      c2_q[0]  <= e1_q[0];
      c2_q[1]  <= e1_q[3];
      c2_q[2]  <= e1_q[6];
      tr2_q    <= tr1_q;
    end
  end

  // stage 3: minors, floor shift, clamp
  logic               v3_q;
  logic signed [31:0] r3_q [NE];
  logic signed [31:0] r3_d [NE];
  logic signed [31:0] c3_q [3];
  logic               tr3_q;

  always_comb begin
    logic signed [64:0] diff;
    for (int i = 0; i < NE; i++) begin
      diff = 65'(pa2_q[i]) - 65'(pb2_q[i]);
      r3_d[i] = mi3_pkg::sat32(66'(diff >>> mi3_pkg::FracBits));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r3_q  <= r3_d;
      c3_q  <= c2_q;
      tr3_q <= tr2_q;
    end
  end

  // stage 4: cofactor products
  logic               v4_q;
  logic signed [63:0] dp4_q [3];
  logic signed [31:0] r4_q [NE];
  logic               tr4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dp4_q[0] <= c3_q[0] * r3_q[0];
      dp4_q[1] <= c3_q[1] * r3_q[1];
      dp4_q[2] <= c3_q[2] * r3_q[2];
      r4_q     <= r3_q;
      tr4_q    <= tr3_q;
    end
  end

  // stage 5: determinant; pick output order
  logic               v5_q;
  logic signed [31:0] det5_q;
  logic signed [31:0] det5_d;
  logic signed [31:0] a5_q [NE];
  logic signed [31:0] a5_d [NE];

  always_comb begin
    logic signed [65:0] sum;
    sum = 66'(dp4_q[0] >>> mi3_pkg::FracBits) + 66'(dp4_q[1] >>> mi3_pkg::FracBits)
        + 66'(dp4_q[2] >>> mi3_pkg::FracBits);
    det5_d = mi3_pkg::sat32(sum);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a5_d[3*i+j] = tr4_q ? r4_q[3*j+i] : r4_q[3*i+j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det5_q <= det5_d;
      a5_q   <= a5_d;
    end
  end

  // divider: index 0 is the setup stage, then one quotient bit per stage
  logic               dv_v_q    [NS+1];
  logic signed [31:0] dv_det_q  [NS+1];
  logic        [31:0] dv_den_q  [NS+1];
  logic        [31:0] dv_rem_q  [NS+1][NE];
  logic        [31:0] dv_num_q  [NS+1][NE];
  logic               dv_ovf_q  [NS+1][NE];
  logic               dv_neg_q  [NS+1][NE];

  logic        [31:0] den0_d;
  logic        [31:0] rem0_d [NE];
  logic        [31:0] num0_d [NE];
  logic               ovf0_d [NE];
  logic               neg0_d [NE];

  always_comb begin
    logic [31:0] mag;
    logic [63:0] wide;
    den0_d = det5_q[31] ? 32'(-det5_q) : 32'(det5_q);
    for (int i = 0; i < NE; i++) begin
      mag = a5_q[i][31] ? 32'(-a5_q[i]) : 32'(a5_q[i]);
      wide = {32'd0, mag} << mi3_pkg::FracBits;
      ovf0_d[i] = wide[63:32] >= den0_d;
      rem0_d[i] = wide[63:32];
      num0_d[i] = wide[31:0];
      neg0_d[i] = a5_q[i][31] ^ det5_q[31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_det_q[0] <= det5_q;
      dv_den_q[0] <= den0_d;
      dv_rem_q[0] <= rem0_d;
      dv_num_q[0] <= num0_d;
      dv_ovf_q[0] <= ovf0_d;
      dv_neg_q[0] <= neg0_d;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [31:0] rem_d [NE];
    logic [31:0] num_d [NE];

    always_comb begin
      logic [32:0] t;
      logic [32:0] s;
      for (int i = 0; i < NE; i++) begin
        t = {dv_rem_q[k][i], dv_num_q[k][i][31]};
        s = t - {1'b0, dv_den_q[k]};
        if (!s[32]) begin
          rem_d[i] = s[31:0];
          num_d[i] = {dv_num_q[k][i][30:0], 1'b1};
        end else begin
          rem_d[i] = t[31:0];
          num_d[i] = {dv_num_q[k][i][30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_det_q[k+1] <= dv_det_q[k];
        dv_den_q[k+1] <= dv_den_q[k];
        dv_rem_q[k+1] <= rem_d;
        dv_num_q[k+1] <= num_d;
        dv_ovf_q[k+1] <= dv_ovf_q[k];
        dv_neg_q[k+1] <= dv_neg_q[k];
      end
    end
  end

  // output stage: sign, clamp, singular
  logic               ov_q;
  logic signed [31:0] res_d [NE];
  logic signed [31:0] res_q [NE];
  logic signed [31:0] det_q;
  logic               sing_q;
  logic               sing_d;

  always_comb begin
    logic [31:0] q;
    sing_d = dv_det_q[NS] == 32'sd0;
    for (int i = 0; i < NE; i++) begin
      q = dv_num_q[NS][i];
      if (sing_d) begin
        res_d[i] = 32'sd0;
      end else if (dv_neg_q[NS][i]) begin
        res_d[i] = (dv_ovf_q[NS][i] || q > 32'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
      end else begin
        res_d[i] = (dv_ovf_q[NS][i] || q[31]) ? 32'sh7FFF_FFFF : 32'(q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv_v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      det_q  <= dv_det_q[NS];
      sing_q <= sing_d;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data.out_e0 = res_q[0];
  assign out_o.data.out_e1 = res_q[1];
  assign out_o.data.out_e2 = res_q[2];
  assign out_o.data.out_e3 = res_q[3];
  assign out_o.data.out_e4 = res_q[4];
  assign out_o.data.out_e5 = res_q[5];
  assign out_o.data.out_e6 = res_q[6];
  assign out_o.data.out_e7 = res_q[7];
  assign out_o.data.out_e8 = res_q[8];
  assign out_o.data.determinant = det_q;
  assign out_o.data.singular = sing_q;

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.singular |->
      out_o.data.determinant == 32'sd0 && out_o.data.out_e0 == 32'sd0 &&
      out_o.data.out_e4 == 32'sd0 && out_o.data.out_e8 == 32'sd0)
    else $error("singular beat with nonzero data");
  a_det_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.singular |-> out_o.data.determinant != 32'sd0)
    else $error("zero determinant not flagged singular");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && !in_i.ready == !out_o.ready)
    else $error("pipeline advanced during stall");
`endif

endmodule

// ----- verif/mi3_tb_pkg.sv -----
`timescale 1ns / 1ps
package mi3_tb_pkg;
  import mi3_pkg::*;

  typedef logic signed [31:0] elem_t;

  // floor shift of an exact product by the fraction width
  function automatic logic signed [127:0] fshift(input logic signed [127:0] v);
    return v >>> FracBits;
  endfunction

  function automatic elem_t clamp32(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -128'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic elem_t minor_of(input elem_t a, input elem_t b, input elem_t c,
                                     input elem_t d);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b) - 128'(c) * 128'(d);
    return clamp32(fshift(p));
  endfunction

  function automatic elem_t div_entry(input elem_t num, input elem_t den);
    logic signed [127:0] q;
    q = (128'(num) <<< FracBits) / 128'(den);
    return clamp32(q);
  endfunction

  // inverse (or transposed inverse) of one matrix beat
  function automatic out_beat_t invert_matrix(input in_beat_t b);
    elem_t e[9];
    elem_t adj[9];
    elem_t res[9];
    elem_t det;
    logic signed [127:0] s;
    out_beat_t o;
    e = '{b.in_e0, b.in_e1, b.in_e2, b.in_e3, b.in_e4, b.in_e5, b.in_e6, b.in_e7, b.in_e8};
    adj[0] = minor_of(e[4], e[8], e[5], e[7]);
    adj[1] = minor_of(e[7], e[2], e[1], e[8]);
    adj[2] = minor_of(e[1], e[5], e[2], e[4]);
    adj[3] = minor_of(e[6], e[5], e[3], e[8]);
    adj[4] = minor_of(e[0], e[8], e[6], e[2]);
    adj[5] = minor_of(e[2], e[3], e[0], e[5]);
    adj[6] = minor_of(e[3], e[7], e[6], e[4]);
    adj[7] = minor_of(e[1], e[6], e[0], e[7]);
    adj[8] = minor_of(e[0], e[4], e[1], e[3]);
    s = fshift(128'(e[0]) * 128'(adj[0])) + fshift(128'(e[3]) * 128'(adj[1]))
        + fshift(128'(e[6]) * 128'(adj[2]));
    det = clamp32(s);
    o = '0;
    if (det == 0) begin
      o.singular = 1'b1;
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        res[3*i+j] = div_entry(b.transpose_out ? adj[3*j+i] : adj[3*i+j], det);
      end
    end
    o = '{res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8], det, 1'b0};
    return o;
  endfunction
endpackage

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import mi3_pkg::*;
  import mi3_tb_pkg::*;

  localparam int Latency    = 39;
  localparam int NumRandom  = 1800;
  localparam int CycleLimit = 400000;
  localparam elem_t One     = 32'sh0001_0000;
  localparam elem_t Max     = 32'sh7FFF_FFFF;
  localparam elem_t Min     = 32'sh8000_0000;

  logic clk_i;
  logic rst_ni;
  mi3_in_if  in_bus();
  mi3_out_if out_bus();

  matrix3x3_inverse_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  typedef struct {
    in_beat_t  mat;
    logic      known;
    out_beat_t want;
  } stim_row_t;

  out_beat_t inverse_q[$];
  int        error_count;
  int        cycle_count;
  logic      stim_done;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic in_beat_t mk(input elem_t a0, a1, a2, a3, a4, a5, a6, a7, a8,
                                  input logic tr);
    return '{a0, a1, a2, a3, a4, a5, a6, a7, a8, tr};
  endfunction

  function automatic elem_t rnd_elem();
    case ($urandom_range(0, 5))
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 8)) * One - 4 * One;
      2: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      3: return $signed($urandom_range(0, 2)) - 1;
      4: return $urandom_range(0, 1) ? Max : Min;
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  function automatic in_beat_t rnd_matrix();
    in_beat_t m;
    m = mk(rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(),
           rnd_elem(), rnd_elem(), rnd_elem(), 1'($urandom()));
    // occasionally force a dependent row
    if ($urandom_range(0, 15) == 0) begin
      m.in_e6 = m.in_e0;
      m.in_e7 = m.in_e1;
      m.in_e8 = m.in_e2;
    end
    return m;
  endfunction

  task automatic send_beat(input in_beat_t m, input out_beat_t want);
    if ($urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= m;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    inverse_q.push_back(want);
    @(negedge clk_i);
  endtask

  // directed rows
  stim_row_t rows[$];
  initial begin
    out_beat_t z;
    out_beat_t idn;
    z = '0;
    z.singular = 1'b1;
    idn = '{One, 0, 0, 0, One, 0, 0, 0, One, One, 1'b0};
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, z});
    rows.push_back('{mk(One, 0, 0, 0, One, 0, 0, 0, One, 1'b0), 1'b1, idn});
    rows.push_back('{mk(One, 0, 0, 0, One, 0, 0, 0, One, 1'b1), 1'b1, idn});
    rows.push_back('{mk(Max, Max, Max, Max, Max, Max, Max, Max, Max, 1'b0), 1'b1, z});
    rows.push_back('{mk(Min, Min, Min, Min, Min, Min, Min, Min, Min, 1'b1), 1'b1, z});
    rows.push_back('{mk(2*One, One, 0, 0, 3*One, One, One, 0, 4*One, 1'b0), 1'b0, z});
    rows.push_back('{mk(2*One, One, 0, 0, 3*One, One, One, 0, 4*One, 1'b1), 1'b0, z});
    // true determinant nonzero but rounds to zero
    rows.push_back('{mk(1, 0, 0, 0, 1, 0, 0, 0, 1, 1'b0), 1'b1, z});
    // determinant saturates
    rows.push_back('{mk(Max, 0, 0, 0, Max, 0, 0, 0, Max, 1'b0), 1'b0, z});
    rows.push_back('{mk(Min, 0, 0, 0, Max, 0, 0, 0, Min, 1'b1), 1'b0, z});
    // tiny determinant, quotients saturate
    rows.push_back('{mk(One, 0, 0, 0, One, 0, 0, 0, 32'sd2, 1'b0), 1'b0, z});
    rows.push_back('{mk(-One, 5*One, 0, 0, One, -3*One, 7*One, 0, -One, 1'b1), 1'b0, z});
    rows.push_back('{mk(Max, Min, Max, Min, Max, Min, Max, Min, -1, 1'b0), 1'b0, z});
    rows.push_back('{mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b1), 1'b0, z});
  end

  initial begin
    stim_row_t r;
    in_beat_t  m;
    in_bus.valid = 1'b0;
    in_bus.data  = '0;
    stim_done    = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (rows[k]) begin
      r = rows[k];
      send_beat(r.mat, r.known ? r.want : invert_matrix(r.mat));
    end
    for (int n = 0; n < NumRandom; n++) begin
      m = rnd_matrix();
      send_beat(m, invert_matrix(m));
    end
    in_bus.valid <= 1'b0;
    stim_done    <= 1'b1;
  end

  // receiver stall pattern
  initial begin
    int mode;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      mode = (cycle_count / 300) % 3;
      case (mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 3) != 0);
        default: out_bus.ready <= ((cycle_count % 7) < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    out_beat_t got;
    out_beat_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = out_bus.data;
      if (inverse_q.size() == 0) begin
        report_mismatch("unexpected beat, determinant", got.determinant, 32'd0);
      end else begin
        want = inverse_q.pop_front();
        if (got.out_e0 !== want.out_e0) report_mismatch("out_e0", got.out_e0, want.out_e0);
        if (got.out_e1 !== want.out_e1) report_mismatch("out_e1", got.out_e1, want.out_e1);
        if (got.out_e2 !== want.out_e2) report_mismatch("out_e2", got.out_e2, want.out_e2);
        if (got.out_e3 !== want.out_e3) report_mismatch("out_e3", got.out_e3, want.out_e3);
        if (got.out_e4 !== want.out_e4) report_mismatch("out_e4", got.out_e4, want.out_e4);
        if (got.out_e5 !== want.out_e5) report_mismatch("out_e5", got.out_e5, want.out_e5);
        if (got.out_e6 !== want.out_e6) report_mismatch("out_e6", got.out_e6, want.out_e6);
        if (got.out_e7 !== want.out_e7) report_mismatch("out_e7", got.out_e7, want.out_e7);
        if (got.out_e8 !== want.out_e8) report_mismatch("out_e8", got.out_e8, want.out_e8);
        if (got.determinant !== want.determinant) begin
          report_mismatch("determinant", got.determinant, want.determinant);
        end
        if (got.singular !== want.singular) begin
          report_mismatch("singular", 32'(got.singular), 32'(want.singular));
        end
      end
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    fork
      begin
        wait (stim_done === 1'b1);
        while (inverse_q.size() != 0) @(posedge clk_i);
        repeat (2 * Latency) @(posedge clk_i);
      end
      begin
        while (cycle_count < CycleLimit) begin
          @(posedge clk_i);
          cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    join_any
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_if.sv
hw/rtl/matrix3x3_inverse_core.sv
verif/mi3_tb_pkg.sv
verif/testbench.sv
